### rtl/rgbc_pkg.sv
package rgbc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COEF_BITS  = 16;

  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int PIX_W      = NUM_CHAN * CHAN_W;
  localparam int LB_W       = 2 * PIX_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_BOX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOBEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GCENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEDGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GCORNER = 3'd5;

  // floor(s / 9) == (s * 7282) >> 16 for every 3x3 sum of 8-bit values
  localparam int BOX_RECIP_W = 13;
  localparam logic [BOX_RECIP_W-1:0] BOX_RECIP = 13'd7282;
  localparam int BOX_SHIFT = 16;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [SIZE_W-1:0]    width;
    logic [SIZE_W-1:0]    height;
    logic [COEF_BITS-1:0] gauss_center;
    logic [COEF_BITS-1:0] gauss_edge;
    logic [COEF_BITS-1:0] gauss_corner;
  } cfg_t;

  typedef struct packed {
    pixel_t [8:0] px;
    logic         last;
  } win_t;

endpackage

### rtl/rgbc_ifaces.sv
interface rgbc_pixel_if import rgbc_pkg::*; ();
  logic        valid;
  logic        ready;
  chan_t       red_in;
  chan_t       green_in;
  chan_t       blue_in;
  logic        frame_start;

  modport source(output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink(input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface rgbc_result_if import rgbc_pkg::*; ();
  logic        valid;
  logic        ready;
  chan_t       red_out;
  chan_t       green_out;
  chan_t       blue_out;
  logic        frame_last;

  modport source(output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink(input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface rgbc_cfg_if import rgbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/rgbc_line_ram.sv
module rgbc_line_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rgbc_cfg_regs.sv
module rgbc_cfg_regs import rgbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rgbc_cfg_if.sink   wr,
  output cfg_t       cfg
);

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);

  logic [MODE_W-1:0]    mode;
  logic [SIZE_W-1:0]    width;
  logic [SIZE_W-1:0]    height;
  logic [COEF_BITS-1:0] gauss_center;
  logic [COEF_BITS-1:0] gauss_edge;
  logic [COEF_BITS-1:0] gauss_corner;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  assign wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BOX;
      width        <= SIZE_W'(640);
      height       <= SIZE_W'(480);
      gauss_center <= COEF_BITS'(8572);
      gauss_edge   <= COEF_BITS'(7565);
      gauss_corner <= COEF_BITS'(6676);
    end else if (wr.valid && wr.ready) begin
      unique case (wr.index)
        REG_MODE:    mode         <= wr.data[MODE_W-1:0];
        REG_WIDTH:   width        <= wr.data[SIZE_W-1:0];
        REG_HEIGHT:  height       <= wr.data[SIZE_W-1:0];
        REG_GCENTER: gauss_center <= COEF_BITS'(wr.data);
        REG_GEDGE:   gauss_edge   <= COEF_BITS'(wr.data);
        REG_GCORNER: gauss_corner <= COEF_BITS'(wr.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode         = mode;
    cfg.width        = clamp_size(width, WIDTH_MAX);
    cfg.height       = clamp_size(height, HEIGHT_MAX);
    cfg.gauss_center = gauss_center;
    cfg.gauss_edge   = gauss_edge;
    cfg.gauss_corner = gauss_corner;
  end

endmodule

### rtl/rgbc_window.sv
module rgbc_window import rgbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  rgbc_pixel_if.sink  pixel,
  output logic        win_valid,
  input  logic        win_ready,
  output win_t        win
);

  logic [COL_W-1:0]  col_cnt, col_cnt_next;
  logic [ROW_W-1:0]  row_cnt, row_cnt_next;
  logic [COL_W-1:0]  col_start, col;
  logic [ROW_W-1:0]  row_start, row;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              emit, last, accept;

  logic              s1_valid;
  pixel_t            s1_cur;
  logic [COL_W-1:0]  s1_col;
  logic              s1_emit;
  logic              s1_last;
  logic              s1_go;
  logic              byp_hit;
  logic [LB_W-1:0]   byp_word;
  logic [LB_W-1:0]   rd_word;
  logic [LB_W-1:0]   word;
  pixel_t            top, mid;
  pixel_t            wc [6];

  // raster position of the incoming pixel
  always_comb begin
    col_start = pixel.frame_start ? '0 : col_cnt;
    row_start = pixel.frame_start ? '0 : row_cnt;
    col = (SIZE_W'(col_start) >= cfg.width)  ? '0 : col_start;
    row = (SIZE_W'(row_start) >= cfg.height) ? '0 : row_start;
    emit = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    last = (SIZE_W'(row) == cfg.height - SIZE_W'(1)) &&
           (SIZE_W'(col) == cfg.width - SIZE_W'(1));
    col_inc = SIZE_W'(col) + SIZE_W'(1);
    row_inc = SIZE_W'(row) + SIZE_W'(1);
    if (col_inc >= cfg.width) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_cnt_next = col_inc[COL_W-1:0];
      row_cnt_next = row;
    end
  end

  assign s1_go       = s1_valid && (!s1_emit || win_ready);
  assign pixel.ready = !s1_valid || s1_go;
  assign accept      = pixel.valid && pixel.ready;

  assign word = byp_hit ? byp_word : rd_word;
  assign top  = word[LB_W-1:PIX_W];
  assign mid  = word[PIX_W-1:0];

  rgbc_line_ram #(
    .ADDR_W (COL_W),
    .DATA_W (LB_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata ({mid, s1_cur}),
    .re    (accept),
    .raddr (col),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt  <= col_cnt_next;
        row_cnt  <= row_cnt_next;
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // same column written on the edge it is read: take the written word
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur   <= {pixel.blue_in, pixel.green_in, pixel.red_in};
      s1_col   <= col;
      s1_emit  <= emit;
      s1_last  <= last;
      byp_hit  <= s1_go && (s1_col == col);
      byp_word <= {mid, s1_cur};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wc[i] <= '0;
      end
    end else if (s1_go) begin
      wc[0] <= wc[3];
      wc[1] <= wc[4];
      wc[2] <= wc[5];
      wc[3] <= top;
      wc[4] <= mid;
      wc[5] <= s1_cur;
    end
  end

  assign win_valid = s1_valid && s1_emit;

  always_comb begin
    win.px[0] = wc[0];
    win.px[1] = wc[3];
    win.px[2] = top;
    win.px[3] = wc[1];
    win.px[4] = wc[4];
    win.px[5] = mid;
    win.px[6] = wc[2];
    win.px[7] = wc[5];
    win.px[8] = s1_cur;
    win.last  = s1_last;
  end

endmodule

### rtl/rgbc_kernel.sv
module rgbc_kernel import rgbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          win_valid,
  output logic          win_ready,
  input  win_t          win,
  rgbc_result_if.source result
);

  localparam int SUM4_W = CHAN_W + 2;
  localparam int SUM9_W = CHAN_W + 4;
  localparam int PC_W   = COEF_BITS + CHAN_W;
  localparam int PE_W   = COEF_BITS + SUM4_W;
  localparam int PB_W   = SUM9_W + BOX_RECIP_W;
  localparam int GSUM_W = COEF_BITS + SUM9_W;
  localparam int GQ_W   = GSUM_W - COEF_BITS;

  // stage a: neighbour sums and sobel
  logic              a_valid, a_last;
  chan_t             a_ctr  [NUM_CHAN];
  logic [SUM4_W-1:0] a_esum [NUM_CHAN];
  logic [SUM4_W-1:0] a_csum [NUM_CHAN];
  logic [SUM9_W-1:0] a_bsum [NUM_CHAN];
  chan_t             a_sob  [NUM_CHAN];

  // stage b: products
  logic              b_valid, b_last;
  logic [PC_W-1:0]   b_pc [NUM_CHAN];
  logic [PE_W-1:0]   b_pe [NUM_CHAN];
  logic [PE_W-1:0]   b_pk [NUM_CHAN];
  logic [PB_W-1:0]   b_pb [NUM_CHAN];
  chan_t             b_sob [NUM_CHAN];

  logic              out_free, b_free, a_free;
  logic [SUM4_W-1:0] esum [NUM_CHAN];
  logic [SUM4_W-1:0] csum [NUM_CHAN];
  logic [SUM4_W-1:0] left [NUM_CHAN];
  logic [SUM4_W-1:0] right [NUM_CHAN];
  logic [SUM4_W-1:0] diff [NUM_CHAN];
  logic [GSUM_W-1:0] gsum [NUM_CHAN];
  logic [GQ_W-1:0]   gq   [NUM_CHAN];
  chan_t             res  [NUM_CHAN];

  assign out_free  = !result.valid || result.ready;
  assign b_free    = !b_valid || out_free;
  assign a_free    = !a_valid || b_free;
  assign win_ready = a_free;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      esum[c]  = SUM4_W'(win.px[1][c]) + SUM4_W'(win.px[3][c]) +
                 SUM4_W'(win.px[5][c]) + SUM4_W'(win.px[7][c]);
      csum[c]  = SUM4_W'(win.px[0][c]) + SUM4_W'(win.px[2][c]) +
                 SUM4_W'(win.px[6][c]) + SUM4_W'(win.px[8][c]);
      left[c]  = SUM4_W'(win.px[0][c]) + SUM4_W'({win.px[3][c], 1'b0}) +
                 SUM4_W'(win.px[6][c]);
      right[c] = SUM4_W'(win.px[2][c]) + SUM4_W'({win.px[5][c], 1'b0}) +
                 SUM4_W'(win.px[8][c]);
      diff[c]  = (left[c] >= right[c]) ? left[c] - right[c] : right[c] - left[c];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      gsum[c] = GSUM_W'(b_pc[c]) + GSUM_W'(b_pe[c]) + GSUM_W'(b_pk[c]);
      gq[c]   = gsum[c][GSUM_W-1:COEF_BITS];
      unique case (cfg.mode)
        MODE_GAUSS: res[c] = (gq[c] > GQ_W'(255)) ? 8'hFF : gq[c][CHAN_W-1:0];
        MODE_SOBEL: res[c] = b_sob[c];
        default:    res[c] = b_pb[c][BOX_SHIFT+CHAN_W-1:BOX_SHIFT];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (win_valid && a_free) begin
        a_valid <= 1'b1;
      end else if (b_free) begin
        a_valid <= 1'b0;
      end
      if (a_valid && b_free) begin
        b_valid <= 1'b1;
      end else if (out_free) begin
        b_valid <= 1'b0;
      end
      if (b_valid && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && a_free) begin
      a_last <= win.last;
      for (int c = 0; c < NUM_CHAN; c++) begin
        a_ctr[c]  <= win.px[4][c];
        a_esum[c] <= esum[c];
        a_csum[c] <= csum[c];
        a_bsum[c] <= SUM9_W'(win.px[4][c]) + SUM9_W'(esum[c]) + SUM9_W'(csum[c]);
        a_sob[c]  <= (diff[c] > SUM4_W'(255)) ? 8'hFF : diff[c][CHAN_W-1:0];
      end
    end
    if (a_valid && b_free) begin
      b_last <= a_last;
      for (int c = 0; c < NUM_CHAN; c++) begin
        b_pc[c]  <= PC_W'(a_ctr[c]) * PC_W'(cfg.gauss_center);
        b_pe[c]  <= PE_W'(a_esum[c]) * PE_W'(cfg.gauss_edge);
        b_pk[c]  <= PE_W'(a_csum[c]) * PE_W'(cfg.gauss_corner);
        b_pb[c]  <= PB_W'(a_bsum[c]) * PB_W'(BOX_RECIP);
        b_sob[c] <= a_sob[c];
      end
    end
    if (b_valid && out_free) begin
      result.red_out    <= res[0];
      result.green_out  <= res[1];
      result.blue_out   <= res[2];
      result.frame_last <= b_last;
    end
  end

endmodule

### rtl/rgb_3x3_convolution_filter_core.sv
// 3x3 rgb convolution filter over a raster pixel stream (box blur, gaussian
// with programmable q0.16 weights, or horizontal sobel). One pixel is taken
// per clock when the result side keeps up; each pixel makes one pass through
// a line-buffer stage, a sum stage, a multiply stage and the result register;
// the pixel that completes a window gives, through those registers, the result
// for the window centre one row and one column back. Border pixels give no
// result and frame_last marks the last interior result of a frame. The
// two previous rows sit in one single-port-write ram of 2048 two-pixel words,
// read and rewritten once per pixel; it has no clearing pass, so its contents
// are meaningful only once a full row has been written. Configuration writes
// are taken at any time but must only be made while the pipeline is empty.
module rgb_3x3_convolution_filter_core import rgbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rgbc_pixel_if.sink    pixel,
  rgbc_result_if.source result,
  rgbc_cfg_if.sink      cfg
);

  cfg_t cfg_q;
  logic win_valid;
  logic win_ready;
  win_t win;

  rgbc_cfg_regs u_cfg_regs (
    .clk (clk),
    .rst (rst),
    .wr  (cfg),
    .cfg (cfg_q)
  );

  rgbc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .pixel     (pixel),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win)
  );

  rgbc_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    win_valid && !win_ready |=> win_valid && $stable(win))
    else $error("window request changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> win_valid && !win_ready)
    else $error("pixel input stalled without a blocked window request");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(win_valid && win_ready, 3) || $past(!win_ready))
    else $error("result appeared without a window request");
`endif

endmodule

### tb/rgbc_filter_checker.sv
`timescale 1ns / 100ps

module rgbc_filter_checker import rgbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  rgbc_pixel_if  pixel,
  rgbc_result_if result,
  rgbc_cfg_if    cfg,
  output int     mismatches,
  output int     awaiting
);

  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int RESET_CENTER  = 8572;
  localparam int RESET_EDGE    = 7565;
  localparam int RESET_CORNER  = 6676;

  typedef pixel_t [8:0] window_t;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } filtered_t;

  filtered_t due_q[$];

  logic [MODE_W-1:0]    mode;
  logic [SIZE_W-1:0]    width_reg;
  logic [SIZE_W-1:0]    height_reg;
  logic [COEF_BITS-1:0] w_center;
  logic [COEF_BITS-1:0] w_edge;
  logic [COEF_BITS-1:0] w_corner;

  pixel_t row_two_up [MAX_WIDTH];
  pixel_t row_one_up [MAX_WIDTH];
  pixel_t col_old [3];
  pixel_t col_new [3];
  int     col;
  int     row;
  int     errs = 0;

  function automatic int clamp_size(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic chan_t convolve(window_t win, int c);
    longint p [9];
    longint acc;
    longint lhs;
    longint rhs;
    int i;
    for (i = 0; i < 9; i++) p[i] = longint'(win[i][c]);
    case (mode)
      MODE_GAUSS: begin
        acc = longint'(w_center) * p[4]
            + longint'(w_edge) * (p[1] + p[3] + p[5] + p[7])
            + longint'(w_corner) * (p[0] + p[2] + p[6] + p[8]);
        acc = acc >> COEF_BITS;
        return (acc > 255) ? chan_t'(255) : chan_t'(acc);
      end
      MODE_SOBEL: begin
        lhs = p[0] + 2 * p[3] + p[6];
        rhs = p[2] + 2 * p[5] + p[8];
        acc = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
        return (acc > 255) ? chan_t'(255) : chan_t'(acc);
      end
      default: begin
        acc = 0;
        for (i = 0; i < 9; i++) acc += p[i];
        return chan_t'(acc / 9);
      end
    endcase
  endfunction

  task automatic take_pixel(pixel_t cur, logic mark);
    int        w;
    int        h;
    pixel_t    top;
    pixel_t    mid;
    window_t   win;
    filtered_t f;
    w = clamp_size(int'(width_reg), MAX_WIDTH);
    h = clamp_size(int'(height_reg), MAX_HEIGHT);
    if (mark) begin
      col = 0;
      row = 0;
    end
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    top = row_two_up[col];
    mid = row_one_up[col];
    row_two_up[col] = mid;
    row_one_up[col] = cur;
    if (row >= 2 && col >= 2) begin
      win[0] = col_old[0]; win[1] = col_new[0]; win[2] = top;
      win[3] = col_old[1]; win[4] = col_new[1]; win[5] = mid;
      win[6] = col_old[2]; win[7] = col_new[2]; win[8] = cur;
      f.red   = convolve(win, 0);
      f.green = convolve(win, 1);
      f.blue  = convolve(win, 2);
      f.last  = (row == h - 1) && (col == w - 1);
      due_q.push_back(f);
    end
    col_old = col_new;
    col_new[0] = top;
    col_new[1] = mid;
    col_new[2] = cur;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_result();
    filtered_t f;
    if (due_q.size() == 0) begin
      $error("result with nothing due: red_out %0d green_out %0d blue_out %0d",
             result.red_out, result.green_out, result.blue_out);
      errs++;
    end else begin
      f = due_q.pop_front();
      compare_field("red_out", f.red, result.red_out);
      compare_field("green_out", f.green, result.green_out);
      compare_field("blue_out", f.blue, result.blue_out);
      compare_field("frame_last", f.last, result.frame_last);
    end
  endtask

  task automatic apply_write();
    case (cfg.index)
      REG_MODE:    mode = cfg.data[MODE_W-1:0];
      REG_WIDTH:   width_reg = cfg.data[SIZE_W-1:0];
      REG_HEIGHT:  height_reg = cfg.data[SIZE_W-1:0];
      REG_GCENTER: w_center = cfg.data[COEF_BITS-1:0];
      REG_GEDGE:   w_edge = cfg.data[COEF_BITS-1:0];
      REG_GCORNER: w_corner = cfg.data[COEF_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_BOX;
      width_reg = SIZE_W'(RESET_WIDTH);
      height_reg = SIZE_W'(RESET_HEIGHT);
      w_center = COEF_BITS'(RESET_CENTER);
      w_edge = COEF_BITS'(RESET_EDGE);
      w_corner = COEF_BITS'(RESET_CORNER);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_two_up[i] = '0;
        row_one_up[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        col_old[i] = '0;
        col_new[i] = '0;
      end
      col = 0;
      row = 0;
      due_q.delete();
    end else begin
      if (result.valid && result.ready) check_result();
      if (cfg.valid && cfg.ready) apply_write();
      if (pixel.valid && pixel.ready)
        take_pixel({pixel.blue_in, pixel.green_in, pixel.red_in}, pixel.frame_start);
    end
    mismatches <= errs;
    awaiting <= due_q.size();
  end

endmodule

### tb/tb_rgb_3x3_convolution_filter_core.sv
`timescale 1ns / 100ps

module tb_rgb_3x3_convolution_filter_core;
  import rgbc_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 10;
  localparam int RANDOM_ITEMS = 1400;
  localparam int STD_CENTER   = 8572;
  localparam int STD_EDGE     = 7565;
  localparam int STD_CORNER   = 6676;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   mismatches;
  int   awaiting;
  int   burst_left = 0;
  int   hold_req = 0;
  int   pixels_sent = 0;
  bit   gaps_on = 1'b1;

  rgbc_pixel_if  pix();
  rgbc_result_if res();
  rgbc_cfg_if    cfg();

  rgb_3x3_convolution_filter_core u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (res),
    .cfg    (cfg)
  );

  rgbc_filter_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pix),
    .result     (res),
    .cfg        (cfg),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int effective_size(int v);
    if (v < 3) return 3;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic chan_t pick_chan(int pat, int x);
    case (pat)
      1: return $urandom_range(0, 1) ? chan_t'(255) : chan_t'(0);
      2: return (x % 4 < 2) ? chan_t'(255 - $urandom_range(0, 3)) : chan_t'($urandom_range(0, 3));
      3: return chan_t'($urandom_range(0, 3));
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
  endtask

  // wait until every request has left the pipeline
  task automatic drain();
    pix.valid <= 1'b0;
    do begin
      while (awaiting != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end while (awaiting != 0);
  endtask

  task automatic set_config(logic [MODE_W-1:0] m, int w, int h, int gc, int ge, int gk);
    drain();
    write_reg(REG_MODE, int'(m));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_GCENTER, gc);
    write_reg(REG_GEDGE, ge);
    write_reg(REG_GCORNER, gk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_px(chan_t r, chan_t g, chan_t b, logic mark);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        pix.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    pix.valid       <= 1'b1;
    pix.red_in      <= r;
    pix.green_in    <= g;
    pix.blue_in     <= b;
    pix.frame_start <= mark;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
  endtask

  task automatic run_frames(int w, int h, int frames, int pat, logic first_mark, bit noise);
    logic mark;
    for (int f = 0; f < frames; f++) begin
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          if (f == 0 && y == 0 && x == 0) mark = first_mark;
          else if (x == 0 && y == 0) mark = $urandom_range(0, 1);
          else mark = noise && ($urandom_range(0, 39) == 0);
          send_px(pick_chan(pat, x), pick_chan(pat, x), pick_chan(pat, x), mark);
        end
      end
    end
  endtask

  // result side: stall patterns of its own, plus long hold-offs on request
  initial begin : receiver
    int seg;
    int style;
    int hold_seen;
    hold_seen = 0;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      style = $urandom_range(0, 3);
      seg = $urandom_range(10, 150);
      while (seg > 0 && hold_seen == hold_req) begin
        case (style)
          0: res.ready <= 1'b1;
          1: res.ready <= 1'($urandom_range(0, 1));
          2: res.ready <= ($urandom_range(0, 7) != 0);
          default: res.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
        seg--;
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int start_count;
    int w;
    int h;
    int gc;
    int ge;
    int gk;
    int sel;
    bit squeeze;
    chan_t v;
    pix.valid       <= 1'b0;
    pix.red_in      <= '0;
    pix.green_in    <= '0;
    pix.blue_in     <= '0;
    pix.frame_start <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first frame unmarked, second frame by wrap-around
    set_config(MODE_BOX, 3, 3, STD_CENTER, STD_EDGE, STD_CORNER);
    for (int i = 0; i < 18; i++) begin
      v = (i < 9) ? chan_t'(255) : chan_t'(0);
      send_px(v, v, v, 1'b0);
    end

    // bright left column, dark right: saturates
    set_config(MODE_SOBEL, 3, 3, STD_CENTER, STD_EDGE, STD_CORNER);
    for (int i = 0; i < 9; i++) begin
      v = (i % 3 == 0) ? chan_t'(255) : (i % 3 == 2) ? chan_t'(0) : chan_t'($urandom_range(0, 255));
      send_px(v, v, v, i == 0);
    end

    // weights summing far above one
    set_config(MODE_GAUSS, 3, 3, 65535, 65535, 65535);
    for (int i = 0; i < 9; i++) send_px(8'hff, 8'hff, 8'hff, i == 0);

    // oversize width and height clamp to the maximum
    set_config(MODE_GAUSS, 4095, 3, STD_CENTER, STD_EDGE, STD_CORNER);
    run_frames(64, 1, 1, 0, 1'b1, 1'b0);
    set_config(MODE_SOBEL, 3, 4095, STD_CENTER, STD_EDGE, STD_CORNER);
    run_frames(3, 40, 1, 0, 1'b1, 1'b0);

    phase = 0;
    start_count = pixels_sent;
    while (pixels_sent < start_count + RANDOM_ITEMS) begin
      squeeze = (phase == 2) || (phase == 9);
      sel = $urandom_range(0, 9);
      if (squeeze) w = 8;
      else if (sel == 0) w = $urandom_range(0, 2);
      else if (sel == 1) w = $urandom_range(11, 40);
      else w = $urandom_range(3, 10);
      if (squeeze) h = 8;
      else if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2);
      else h = $urandom_range(3, 6);
      case ($urandom_range(0, 3))
        0: begin
          gk = $urandom_range(0, 8000);
          ge = $urandom_range(0, (65536 - 4 * gk) / 4);
          gc = 65536 - 4 * ge - 4 * gk;
          if (gc > 65535) gc = 65535;
        end
        1: begin
          gc = $urandom_range(0, 65535);
          ge = $urandom_range(0, 65535);
          gk = $urandom_range(0, 65535);
        end
        2: begin
          gc = STD_CENTER;
          ge = STD_EDGE;
          gk = STD_CORNER;
        end
        default: begin
          gc = $urandom_range(0, 1) ? 65535 : 0;
          ge = $urandom_range(0, 1) ? 65535 : 0;
          gk = $urandom_range(0, 1) ? 65535 : 0;
        end
      endcase
      set_config(MODE_W'($urandom_range(0, 3)), w, h, gc, ge, gk);
      gaps_on = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (squeeze) hold_req++;
      run_frames(effective_size(w), effective_size(h), squeeze ? 2 : $urandom_range(1, 3),
                 $urandom_range(0, 6), 1'b1, !squeeze && ($urandom_range(0, 3) == 0));
      phase++;
    end

    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
